### design/flagged_alu_register_machine_top_defines.svh
// Assertion macros shared by the flagged ALU register machine RTL.
// No dependencies; expects i_clk and i_rst_n in the including module.
`ifndef FLAGGED_ALU_REGISTER_MACHINE_TOP_DEFINES_SVH
`define FLAGGED_ALU_REGISTER_MACHINE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define FARM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FARM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/farm_pkg.sv
// Shared types, codes and constants of the flagged ALU register machine.
// No dependencies.
package farm_pkg;

    localparam int unsigned DEF_RAM_DEPTH = 256;
    localparam int unsigned DEF_NUM_REGS  = 8;

    localparam logic [31:0] SEED_MUL   = 32'd2654435761;
    localparam logic [31:0] ADDR_RESET = 32'd12345;

    typedef logic [31:0] t_word;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_AND   = 3'd2,
        OP_EOR   = 3'd3,
        OP_LSL   = 3'd4,
        OP_STMEM = 3'd5,
        OP_LOAD  = 3'd6,
        OP_ADDI  = 3'd7
    } t_opcode;

    typedef enum logic {
        CMD_EXEC    = 1'b0,
        CMD_RESTART = 1'b1
    } t_command;

    typedef struct packed {
        logic x;
        logic n;
        logic z;
        logic v;
        logic c;
    } t_flags;

    // register file commit controls
    typedef struct packed {
        logic wr_en;
        logic restart;
    } t_rf_ctl;

    function automatic t_word seed_word(input int unsigned idx);
        return t_word'(idx) * SEED_MUL + 32'd1;
    endfunction

    function automatic t_word seed_sum(input int unsigned count);
        t_word acc;
        acc = '0;
        for (int unsigned i = 0; i < count; i++) begin
            acc = acc + seed_word(i);
        end
        return acc;
    endfunction

endpackage

### design/farm_if.sv
// Handshake interfaces of the flagged ALU register machine: instruction in,
// result out, address register write. Depends on farm_pkg.
interface farm_in_if;
    logic                   valid;
    logic                   ready;
    farm_pkg::t_command     command;
    farm_pkg::t_opcode      opcode;
    logic [2:0]             dest_reg;
    logic signed [31:0]     operand_b;

    modport source (output valid, command, opcode, dest_reg, operand_b, input ready);
    modport sink   (input valid, command, opcode, dest_reg, operand_b, output ready);
endinterface

interface farm_out_if;
    logic                   valid;
    logic                   ready;
    logic signed [31:0]     result_value;
    farm_pkg::t_flags       flags;
    logic signed [31:0]     checksum;

    modport source (output valid, result_value, flags, checksum, input ready);
    modport sink   (input valid, result_value, flags, checksum, output ready);
endinterface

interface farm_cfg_if;
    logic                   valid;
    logic                   ready;
    logic [31:0]            data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### design/farm_addr_unit.sv
// Address register and its multi-cycle reduction to a RAM word index.
// Depends on farm_pkg and farm_cfg_if.
module farm_addr_unit #(
    parameter int unsigned RAM_DEPTH = farm_pkg::DEF_RAM_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    farm_cfg_if.sink                     i_cfg,
    output farm_pkg::t_word              o_addr_word,
    output logic [$clog2(RAM_DEPTH)-1:0] o_addr_idx,
    output logic                         o_busy
);
    import farm_pkg::*;

    localparam int unsigned AW = $clog2(RAM_DEPTH);
    localparam int unsigned CW = AW + 5;
    localparam logic [CW-1:0] DEPTH_C = CW'(RAM_DEPTH);
    localparam logic [AW-1:0] RESET_IDX = AW'(ADDR_RESET % RAM_DEPTH);
    localparam logic [3:0] LAST_STEP = 4'd8;

    typedef logic [AW-1:0] t_wt_tab [32];

    // weight of each address bit modulo the RAM depth
    function automatic t_wt_tab build_weights();
        t_wt_tab     wt;
        int unsigned acc;
        acc = 1 % RAM_DEPTH;
        for (int i = 0; i < 32; i++) begin
            wt[i] = AW'(acc);
            acc   = (acc * 2) % RAM_DEPTH;
        end
        return wt;
    endfunction

    localparam t_wt_tab WT = build_weights();

    t_word         r_addr_word;
    t_word         r_shift;
    logic [CW-1:0] r_acc;
    logic [AW-1:0] r_addr_idx;
    logic [3:0]    r_step;
    logic          r_busy;
    logic [CW-1:0] chunk_sum;
    logic [CW-1:0] sub_val;
    logic [CW-1:0] n_acc;

    assign i_cfg.ready = 1'b1;

    // steps 0-3: add the weights of one address byte each, sum stays below 32 * depth
    // steps 4-8: compare and subtract 16, 8, 4, 2 and 1 times the depth
    always_comb begin
        chunk_sum = '0;
        for (int j = 0; j < 8; j++) begin
            if (r_shift[j]) begin
                chunk_sum = chunk_sum + CW'(WT[{r_step[1:0], 3'(j)}]);
            end
        end
        sub_val = DEPTH_C << (LAST_STEP - r_step);
        if (r_step < 4'd4) begin
            n_acc = r_acc + chunk_sum;
        end else if (r_acc >= sub_val) begin
            n_acc = r_acc - sub_val;
        end else begin
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_word <= ADDR_RESET;
            r_addr_idx  <= RESET_IDX;
            r_busy      <= 1'b0;
            r_step      <= '0;
        end else if (i_cfg.valid) begin
            r_addr_word <= i_cfg.data;
            r_shift     <= i_cfg.data;
            r_acc       <= '0;
            r_step      <= '0;
            r_busy      <= 1'b1;
        end else if (r_busy) begin
            r_shift <= {8'd0, r_shift[31:8]};
            r_acc   <= n_acc;
            r_step  <= r_step + 4'd1;
            if (r_step == LAST_STEP) begin
                r_busy     <= 1'b0;
                r_addr_idx <= AW'(n_acc);
            end
        end
    end

    assign o_addr_word = r_addr_word;
    assign o_addr_idx  = r_addr_idx;
    assign o_busy      = r_busy;

endmodule

### design/farm_dmem.sv
// Data RAM with a clearing pass after reset and store-to-load forwarding.
// Depends on farm_pkg.
module farm_dmem #(
    parameter int unsigned RAM_DEPTH = farm_pkg::DEF_RAM_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(RAM_DEPTH)-1:0] i_addr,
    input  logic                         i_wr_en,
    input  farm_pkg::t_word              i_wr_data,
    output farm_pkg::t_word              o_rd_data,
    output logic                         o_busy
);
    import farm_pkg::*;

    localparam int unsigned AW = $clog2(RAM_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(RAM_DEPTH - 1);

    t_word         mem [RAM_DEPTH];
    t_word         r_rd;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_idx;
    logic          r_ls_valid;
    logic [AW-1:0] r_ls_addr;
    t_word         r_ls_data;

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_idx] <= '0;
        end else if (i_wr_en) begin
            mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_ls_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_IDX) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_wr_en && !r_clr_busy) begin
                r_ls_valid <= 1'b1;
                r_ls_addr  <= i_addr;
                r_ls_data  <= i_wr_data;
            end
        end
    end

    // the last store may land on the same edge as the read
    assign o_rd_data = (r_ls_valid && r_ls_addr == i_addr) ? r_ls_data : r_rd;
    assign o_busy    = r_clr_busy;

endmodule

### design/farm_regfile.sv
// Register file: two-read one-write memory, per-entry valid bits that
// restart clears (invalid reads as seed), last-write forwarding. Uses farm_pkg.
module farm_regfile #(
    parameter int unsigned NUM_REGS = farm_pkg::DEF_NUM_REGS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [$clog2(NUM_REGS)-1:0] i_rd_addr_a,
    input  logic [$clog2(NUM_REGS)-1:0] i_rd_addr_b,
    input  logic [$clog2(NUM_REGS)-1:0] i_cur_addr_a,
    input  logic [$clog2(NUM_REGS)-1:0] i_cur_addr_b,
    input  farm_pkg::t_rf_ctl           i_ctl,
    input  logic [$clog2(NUM_REGS)-1:0] i_wr_addr,
    input  farm_pkg::t_word             i_wr_data,
    output farm_pkg::t_word             o_data_a,
    output farm_pkg::t_word             o_data_b
);
    import farm_pkg::*;

    localparam int unsigned RW = $clog2(NUM_REGS);

    typedef t_word t_seed_tab [NUM_REGS];

    function automatic t_seed_tab build_seeds();
        t_seed_tab tab;
        for (int unsigned i = 0; i < NUM_REGS; i++) begin
            tab[i] = seed_word(i);
        end
        return tab;
    endfunction

    localparam t_seed_tab SEEDS = build_seeds();

    t_word         mem [NUM_REGS];
    t_word         r_rd_a;
    t_word         r_rd_b;
    logic [NUM_REGS-1:0] r_valid;
    logic          r_lw_valid;
    logic [RW-1:0] r_lw_addr;
    t_word         r_lw_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= mem[i_rd_addr_a];
            r_rd_b <= mem[i_rd_addr_b];
        end
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.restart) begin
            r_valid    <= '0;
            r_lw_valid <= 1'b0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
            r_lw_valid         <= 1'b1;
            r_lw_addr          <= i_wr_addr;
            r_lw_data          <= i_wr_data;
        end
    end

    // newest write wins, then stored word, then seed for untouched entries
    always_comb begin
        priority if (r_lw_valid && r_lw_addr == i_cur_addr_a) begin
            o_data_a = r_lw_data;
        end else if (r_valid[i_cur_addr_a]) begin
            o_data_a = r_rd_a;
        end else begin
            o_data_a = SEEDS[i_cur_addr_a];
        end
    end

    always_comb begin
        priority if (r_lw_valid && r_lw_addr == i_cur_addr_b) begin
            o_data_b = r_lw_data;
        end else if (r_valid[i_cur_addr_b]) begin
            o_data_b = r_rd_b;
        end else begin
            o_data_b = SEEDS[i_cur_addr_b];
        end
    end

endmodule

### design/farm_alu.sv
// Execute unit: result, write enables and X N Z V C flags for one
// instruction. Depends on farm_pkg.
module farm_alu (
    input  farm_pkg::t_opcode i_op,
    input  farm_pkg::t_word   i_x,
    input  farm_pkg::t_word   i_y,
    input  farm_pkg::t_word   i_b,
    input  farm_pkg::t_word   i_m,
    input  farm_pkg::t_flags  i_flags,
    output farm_pkg::t_word   o_res,
    output farm_pkg::t_flags  o_flags,
    output logic              o_wr_reg,
    output logic              o_wr_mem
);
    import farm_pkg::*;

    t_word       opnd;
    logic [32:0] sum33;
    t_word       diff;
    logic [32:0] shl33;
    logic        arith;
    logic        av;
    logic        ac;
    logic        neg;
    logic        zero;

    always_comb begin
        opnd  = (i_op == OP_ADDI) ? i_b : i_y;
        sum33 = {1'b0, i_x} + {1'b0, opnd};
        diff  = i_x - i_y;
        // bit 32 is the last bit shifted out, zero for a zero count
        shl33 = {1'b0, i_x} << i_b[4:0];

        o_res    = '0;
        o_wr_reg = 1'b0;
        o_wr_mem = 1'b0;
        arith    = 1'b0;
        av       = 1'b0;
        ac       = 1'b0;

        unique case (i_op)
            OP_ADD, OP_ADDI: begin
                o_res    = sum33[31:0];
                o_wr_reg = 1'b1;
                arith    = 1'b1;
                av       = ((i_x[31] ^ sum33[31]) & (opnd[31] ^ sum33[31]));
                ac       = sum33[32];
            end
            OP_SUB: begin
                o_res    = diff;
                o_wr_reg = 1'b1;
                arith    = 1'b1;
                av       = ((i_x[31] ^ i_y[31]) & (i_x[31] ^ diff[31]));
                ac       = (i_x < i_y);
            end
            OP_AND: begin
                o_res    = i_x & i_y;
                o_wr_reg = 1'b1;
            end
            OP_EOR: begin
                o_res    = i_x ^ i_y;
                o_wr_reg = 1'b1;
            end
            OP_LSL: begin
                o_res    = shl33[31:0];
                o_wr_reg = 1'b1;
                arith    = 1'b1;
                ac       = shl33[32];
            end
            OP_STMEM: begin
                o_res    = i_y;
                o_wr_mem = 1'b1;
            end
            OP_LOAD: begin
                o_res    = i_m;
                o_wr_reg = 1'b1;
            end
            default: begin
                o_res = '0;
            end
        endcase

        neg  = o_res[31];
        zero = (o_res == '0);

        if (arith) begin
            o_flags = '{x: ac, n: neg, z: zero, v: av, c: ac};
        end else begin
            o_flags = '{x: i_flags.x, n: neg, z: zero, v: 1'b0, c: 1'b0};
        end
    end

endmodule

### design/flagged_alu_register_machine_top.sv
// Top level of the flagged ALU register machine: decode, execute stage,
// output register, running register sum. Depends on farm_pkg, farm_if.sv,
// farm_addr_unit, farm_dmem, farm_regfile, farm_alu and the defines header.

// One instruction word is accepted per clock unless the input is held off or
// the output stalls, and one result word comes out for each, in order. An
// instruction accepted at one edge reads the register file and data RAM
// there and executes in the next cycle; it writes back and its result enters
// the output register when the execute stage advances. The rate is set by
// this single read-execute-write loop, with the newest register and RAM write
// forwarded to the next instruction. After reset the input is held off while
// the data RAM is cleared one word per cycle; after each address register
// write it is held off while the address is reduced to a RAM index (summing
// per-bit weights, then compare and subtract). Address writes are taken at
// any time and must only be issued while no instruction is in flight.
`include "flagged_alu_register_machine_top_defines.svh"

module flagged_alu_register_machine_top #(
    parameter int unsigned RAM_DEPTH = farm_pkg::DEF_RAM_DEPTH,
    parameter int unsigned NUM_REGS  = farm_pkg::DEF_NUM_REGS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    farm_in_if.sink    i_in,
    farm_cfg_if.sink   i_cfg,
    farm_out_if.source o_out
);
    import farm_pkg::*;

    localparam int unsigned RW = $clog2(NUM_REGS);
    localparam int unsigned AW = $clog2(RAM_DEPTH);
    localparam t_word SEED_SUM = seed_sum(NUM_REGS);

    typedef logic [RW-1:0] t_ridx;
    typedef logic [3:0]    t_wt_tab  [32];
    typedef t_ridx         t_mod_tab [256];

    // weight of each bit position modulo the register count
    function automatic t_wt_tab build_weights();
        t_wt_tab     wt;
        int unsigned acc;
        acc = 1 % NUM_REGS;
        for (int i = 0; i < 32; i++) begin
            wt[i] = 4'(acc);
            acc   = (acc * 2) % NUM_REGS;
        end
        return wt;
    endfunction

    function automatic t_mod_tab build_mod();
        t_mod_tab tab;
        for (int unsigned i = 0; i < 256; i++) begin
            tab[i] = RW'(i % NUM_REGS);
        end
        return tab;
    endfunction

    localparam t_wt_tab  WT      = build_weights();
    localparam t_mod_tab MOD_TAB = build_mod();

    // 32-bit word mod register count: two weighted folds, then a table
    function automatic t_ridx reg_index(input t_word val);
        logic [8:0] f1;
        logic [7:0] f2;
        f1 = '0;
        for (int i = 0; i < 32; i++) begin
            if (val[i]) begin
                f1 = f1 + 9'(WT[i]);
            end
        end
        f2 = '0;
        for (int i = 0; i < 9; i++) begin
            if (f1[i]) begin
                f2 = f2 + 8'(WT[i]);
            end
        end
        return MOD_TAB[f2];
    endfunction

    // address unit and data RAM
    t_word         addr_word;
    logic [AW-1:0] addr_idx;
    logic          addr_busy;
    logic          dmem_busy;
    t_word         mem_data;

    // execute stage
    logic          r_s1_valid;
    t_command      r_s1_cmd;
    t_opcode       r_s1_op;
    t_ridx         r_s1_d;
    t_ridx         r_s1_s;
    t_word         r_s1_b;

    // architectural flags and register sum
    t_flags        r_flags;
    t_word         r_reg_sum;

    // output register
    logic          r_out_valid;
    t_word         r_out_result;
    t_flags        r_out_flags;
    t_word         r_out_regsum;

    logic          in_accept;
    logic          s1_adv;
    logic          s1_exec;
    logic          s1_restart;
    t_ridx         dec_d;
    t_ridx         dec_s;
    t_word         x_val;
    t_word         y_val;
    t_word         alu_res;
    t_flags        alu_flags;
    logic          alu_wr_reg;
    logic          alu_wr_mem;
    t_rf_ctl       rf_ctl;
    t_flags        n_flags;
    t_word         n_reg_sum;
    t_word         n_result;

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !addr_busy && !dmem_busy && (!r_s1_valid || s1_adv);
    assign in_accept  = i_in.valid && i_in.ready;

    assign dec_d = MOD_TAB[8'(i_in.dest_reg)];
    assign dec_s = reg_index(t_word'(i_in.operand_b));

    farm_addr_unit #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_addr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .o_addr_word (addr_word),
        .o_addr_idx  (addr_idx),
        .o_busy      (addr_busy)
    );

    farm_dmem #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_addr    (addr_idx),
        .i_wr_en   (s1_adv && s1_exec && alu_wr_mem),
        .i_wr_data (alu_res),
        .o_rd_data (mem_data),
        .o_busy    (dmem_busy)
    );

    farm_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (in_accept),
        .i_rd_addr_a  (dec_d),
        .i_rd_addr_b  (dec_s),
        .i_cur_addr_a (r_s1_d),
        .i_cur_addr_b (r_s1_s),
        .i_ctl        (rf_ctl),
        .i_wr_addr    (r_s1_d),
        .i_wr_data    (alu_res),
        .o_data_a     (x_val),
        .o_data_b     (y_val)
    );

    farm_alu u_alu (
        .i_op     (r_s1_op),
        .i_x      (x_val),
        .i_y      (y_val),
        .i_b      (r_s1_b),
        .i_m      (mem_data),
        .i_flags  (r_flags),
        .o_res    (alu_res),
        .o_flags  (alu_flags),
        .o_wr_reg (alu_wr_reg),
        .o_wr_mem (alu_wr_mem)
    );

    assign s1_exec    = (r_s1_cmd == CMD_EXEC);
    assign s1_restart = (r_s1_cmd == CMD_RESTART);

    assign rf_ctl.wr_en   = s1_adv && s1_exec && alu_wr_reg;
    assign rf_ctl.restart = s1_adv && s1_restart;

    always_comb begin
        if (s1_restart) begin
            n_flags   = '0;
            n_reg_sum = SEED_SUM;
            n_result  = '0;
        end else begin
            n_flags  = alu_flags;
            n_result = alu_res;
            // the destination's old value leaves the sum, the new one enters
            n_reg_sum = alu_wr_reg ? (r_reg_sum + alu_res - x_val) : r_reg_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd <= i_in.command;
            r_s1_op  <= i_in.opcode;
            r_s1_d   <= dec_d;
            r_s1_s   <= dec_s;
            r_s1_b   <= t_word'(i_in.operand_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_reg_sum   <= SEED_SUM;
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_flags     <= n_flags;
            r_reg_sum   <= n_reg_sum;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_result <= n_result;
            r_out_flags  <= n_flags;
            r_out_regsum <= n_reg_sum;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = signed'(r_out_result);
    assign o_out.flags        = r_out_flags;
    assign o_out.checksum     = signed'(r_out_regsum + t_word'(5'(r_out_flags)) + addr_word);

    `FARM_ASSERT_NEXT(a_restart_reseeds, s1_adv && s1_restart,
        r_reg_sum == SEED_SUM && r_flags == '0, "restart did not reseed sum and flags")
    `FARM_ASSERT_NEXT(a_store_keeps_sum, s1_adv && s1_exec && r_s1_op == OP_STMEM,
        r_reg_sum == $past(r_reg_sum), "store changed the register sum")
    `FARM_ASSERT_NEXT(a_accept_fills_stage, in_accept,
        r_s1_valid, "accepted word did not reach the execute stage")
    `FARM_ASSERT_IMPL(a_out_flags_current, r_out_valid,
        r_out_flags == r_flags, "pending result flags differ from flag register")

endmodule
